// File: rtl/sqfr_pkg.sv
// Shared types and constants of the status query frame responder.
package sqfr_pkg;

  localparam int unsigned QUERY_BYTES = 6;
  localparam int unsigned STORE_DEPTH = 5;
  localparam int unsigned REPLY_LEN   = 10;
  localparam int unsigned IDX_W       = $clog2(REPLY_LEN);
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_AW;
  localparam int unsigned ADDR_W      = 5;

  typedef enum logic [2:0] {
    REG_QUERY_HEAD    = 3'd0,
    REG_QUERY_COMMAND = 3'd1,
    REG_REPLY_HEAD    = 3'd2,
    REG_REPLY_COMMAND = 3'd3,
    REG_OWN_VEHICLE   = 3'd4,
    REG_OWN_SEAT      = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_LENGTH   = 3'd1,
    VERDICT_HEAD     = 3'd2,
    VERDICT_COMMAND  = 3'd3,
    VERDICT_CHECKSUM = 3'd4,
    VERDICT_VEHICLE  = 3'd5,
    VERDICT_SEAT     = 3'd6
  } verdict_e;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_ABORT = 1'b1;

  typedef struct packed {
    logic [7:0] query_head;
    logic [7:0] query_command;
    logic [7:0] reply_head;
    logic [7:0] reply_command;
    logic [7:0] own_vehicle;
    logic [7:0] own_seat;
  } cfg_t;

  // One classified frame, handed from the front to the back.
  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  seq;
    logic [3:0]  pins;
    logic [15:0] good;
    logic [15:0] bad;
  } job_t;

endpackage

// File: rtl/sqfr_regs.sv
// Configuration register file behind the APB-style port.
module sqfr_regs
  import sqfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_QUERY_HEAD:    cfg_d.query_head    = pwdata[7:0];
        REG_QUERY_COMMAND: cfg_d.query_command = pwdata[7:0];
        REG_REPLY_HEAD:    cfg_d.reply_head    = pwdata[7:0];
        REG_REPLY_COMMAND: cfg_d.reply_command = pwdata[7:0];
        REG_OWN_VEHICLE:   cfg_d.own_vehicle   = pwdata[7:0];
        REG_OWN_SEAT:      cfg_d.own_seat      = pwdata[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QUERY_HEAD:    prdata = {24'd0, cfg_q.query_head};
      REG_QUERY_COMMAND: prdata = {24'd0, cfg_q.query_command};
      REG_REPLY_HEAD:    prdata = {24'd0, cfg_q.reply_head};
      REG_REPLY_COMMAND: prdata = {24'd0, cfg_q.reply_command};
      REG_OWN_VEHICLE:   prdata = {24'd0, cfg_q.own_vehicle};
      REG_OWN_SEAT:      prdata = {24'd0, cfg_q.own_seat};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/sqfr_front.sv
// Front part: buffers received bytes and classifies each finished frame.
module sqfr_front
  import sqfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic [3:0]  sensor_pins_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       xor_q, xor_d;
  logic [15:0]      good_q, good_d;
  logic [15:0]      bad_q, bad_d;
  logic [7:0]       store_q [STORE_DEPTH];
  verdict_e         verdict;
  logic             is_byte;

  assign is_byte = accept_i && (cmd_i == CMD_BYTE);
  assign xor_d   = xor_q ^ rx_byte_i;
  assign count_d = (count_q == {CNT_W{1'b1}}) ? count_q : count_q + CNT_W'(1);

  // The first failing check wins; bytes 0..3 are already stored when the length is right.
  always_comb begin
    if (count_d != CNT_W'(QUERY_BYTES))             verdict = VERDICT_LENGTH;
    else if (store_q[0] != cfg_i.query_head)        verdict = VERDICT_HEAD;
    else if (store_q[1] != cfg_i.query_command)     verdict = VERDICT_COMMAND;
    else if (xor_d != 8'd0)                         verdict = VERDICT_CHECKSUM;
    else if (store_q[2] != cfg_i.own_vehicle)       verdict = VERDICT_VEHICLE;
    else if (store_q[3] != cfg_i.own_seat)          verdict = VERDICT_SEAT;
    else                                            verdict = VERDICT_OK;
  end

  assign push_o = is_byte && frame_end_i;
  assign good_d = good_q + 16'd1;
  assign bad_d  = bad_q + 16'd1;

  always_comb begin
    job_o.verdict = verdict;
    job_o.seq     = store_q[4];
    job_o.pins    = sensor_pins_i;
    job_o.good    = (verdict == VERDICT_OK) ? good_d : good_q;
    job_o.bad     = (verdict == VERDICT_OK) ? bad_q : bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else if (accept_i) begin
      if (cmd_i == CMD_ABORT || frame_end_i) begin
        count_q <= '0;
        xor_q   <= '0;
      end else begin
        count_q <= count_d;
        xor_q   <= xor_d;
      end
      if (push_o) begin
        good_q <= job_o.good;
        bad_q  <= job_o.bad;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (is_byte && count_q == CNT_W'(i)) begin
        store_q[i] <= rx_byte_i;
      end
    end
  end

endmodule

// File: rtl/sqfr_queue.sv
// Short job queue between the front and the back.
module sqfr_queue
  import sqfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   fill_q, fill_d;

  assign full_o  = (fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) fill_d = fill_q + (QUEUE_AW+1)'(1);
    else if (!push_i && pop_i) fill_d = fill_q - (QUEUE_AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/sqfr_back.sv
// Back part: expands each queued job into reply or reject words.
module sqfr_back
  import sqfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o,
  output verdict_e    verdict_o,
  output logic [15:0] good_o,
  output logic [15:0] bad_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  verdict_e         verdict_q;
  logic [15:0]      good_q, bad_q;
  logic             load;
  logic [7:0]       checksum;

  assign load = job_valid_i && (!valid_q || ready_i);

  // Sensor bytes are 0 or 1, so together they add only a parity bit.
  assign checksum = cfg_i.reply_head ^ cfg_i.reply_command ^ cfg_i.own_vehicle
                  ^ cfg_i.own_seat ^ job_i.seq ^ {7'd0, ^(~job_i.pins)};

  always_comb begin
    if (job_i.verdict != VERDICT_OK) begin
      byte_d = 8'd0;
      last_d = 1'b1;
    end else begin
      last_d = (idx_q == IDX_W'(REPLY_LEN - 1));
      case (idx_q)
        4'd0:    byte_d = cfg_i.reply_head;
        4'd1:    byte_d = cfg_i.reply_command;
        4'd2:    byte_d = cfg_i.own_vehicle;
        4'd3:    byte_d = cfg_i.own_seat;
        4'd4, 4'd5, 4'd6, 4'd7:
                 byte_d = {7'd0, ~job_i.pins[idx_q[1:0]]};
        4'd8:    byte_d = job_i.seq;
        4'd9:    byte_d = checksum;
        default: byte_d = 8'd0;
      endcase
    end
  end

  always_comb begin
    pop_o   = load && last_d;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_d ? '0 : idx_q + IDX_W'(1);
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= byte_d;
      last_q    <= last_d;
      verdict_q <= job_i.verdict;
      good_q    <= job_i.good;
      bad_q     <= job_i.bad;
    end
  end

  assign valid_o      = valid_q;
  assign reply_byte_o = byte_q;
  assign reply_last_o = last_q;
  assign verdict_o    = verdict_q;
  assign good_o       = good_q;
  assign bad_o        = bad_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(REPLY_LEN - 1))
    else $error("reply index out of range");

  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> job_valid_i)
    else $error("job left the queue before its reply was finished");

  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && verdict_q != VERDICT_OK |-> last_q && byte_q == 8'd0)
    else $error("reject result is not a single zero word");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && last_q)
    else $error("job popped without its last word");

endmodule

// File: rtl/status_query_frame_responder.sv
// Status query frame responder: checks received query frames and sends replies.
// Input: one byte per cycle while the job queue has room; a frame end enqueues its job.
// Output: the first word follows the end byte through the job queue and the output register,
// then one word per cycle while m_tready is high; a reply is ten words, a reject is one.
// The two-entry job queue sets how many finished frames may wait on the output.
// Reset clears configuration, counters, frame progress, queue and output valid at once.
module status_query_frame_responder
  import sqfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // rx_byte[7:0], sensor_pins[11:8], zero[15:12]
  input  logic [0:0]        s_tuser,   // cmd[0]
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // reply_byte[7:0], good_frames[23:8], bad_frames[39:24]
  output logic [2:0]        m_tuser,   // verdict[2:0]
  output logic              m_tlast
);

  cfg_t        cfg;
  logic        accept;
  logic        push, full, pop, job_valid;
  job_t        job_in, job_out;
  logic [7:0]  reply_byte;
  verdict_e    verdict;
  logic [15:0] good, bad;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  sqfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sqfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .cmd_i         (s_tuser[0]),
    .rx_byte_i     (s_tdata[7:0]),
    .frame_end_i   (s_tlast),
    .sensor_pins_i (s_tdata[11:8]),
    .push_o        (push),
    .job_o         (job_in)
  );

  sqfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  sqfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .valid_o      (m_tvalid),
    .ready_i      (m_tready),
    .reply_byte_o (reply_byte),
    .reply_last_o (m_tlast),
    .verdict_o    (verdict),
    .good_o       (good),
    .bad_o        (bad)
  );

  assign m_tdata = {bad, good, reply_byte};
  assign m_tuser = verdict;

endmodule
